FILE: hw/rtl/point_in_triangle_3d_unit_macros.svh
// ---------------------------------------------------------------------------
// Point in triangle 3D unit: assertion macros
// Shared concurrent assertion forms for the pipeline checks.
// ---------------------------------------------------------------------------
`ifndef POINT_IN_TRIANGLE_3D_UNIT_MACROS_SVH
`define POINT_IN_TRIANGLE_3D_UNIT_MACROS_SVH

// same-cycle implication
`define PIT3D_ASSERT_IMP(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// next-cycle implication
`define PIT3D_ASSERT_NXT(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

FILE: hw/rtl/pit3d_pkg.sv
// ---------------------------------------------------------------------------
// Point in triangle 3D package
// Widths, stage indexes and shared types of the barycentric test pipeline.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package pit3d_pkg;

   localparam int COORD_WIDTH = 16;
   localparam int DIFF_W      = COORD_WIDTH + 1;
   localparam int PROD1_W     = 2 * DIFF_W;
   localparam int DOT_W       = PROD1_W + 2;
   localparam int LO_W        = (DOT_W + 1) / 2;
   localparam int HI_W        = DOT_W - LO_W;
   localparam int PROD2_W     = 2 * DOT_W;
   localparam int RES_W       = PROD2_W + 3;

   localparam int NUM_STAGES  = 7;
   localparam int STG_DIFF    = 0;
   localparam int STG_PROD    = 1;
   localparam int STG_DOT     = 2;
   localparam int STG_PART    = 3;
   localparam int STG_MUL     = 4;
   localparam int STG_NUMER   = 5;
   localparam int STG_OUT     = 6;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [DIFF_W-1:0]      diff_type;
   typedef logic signed [PROD1_W-1:0]     prod1_type;
   typedef logic signed [DOT_W-1:0]       dot_type;
   typedef logic signed [PROD2_W-1:0]     prod2_type;
   typedef logic signed [RES_W-1:0]       res_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type z;
   } vec3_type;

   typedef struct packed {
      logic [NUM_STAGES-1:0] load;
   } pipe_ctrl_type;

endpackage

FILE: hw/rtl/pit3d_chan_if.sv
// ---------------------------------------------------------------------------
// Point in triangle 3D channels
// Valid/ready request and response channels with their payload.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pit3d_req_if;
   logic                  valid;
   logic                  ready;
   pit3d_pkg::coord_type  point_x;
   pit3d_pkg::coord_type  point_y;
   pit3d_pkg::coord_type  point_z;
   pit3d_pkg::coord_type  first_x;
   pit3d_pkg::coord_type  first_y;
   pit3d_pkg::coord_type  first_z;
   pit3d_pkg::coord_type  second_x;
   pit3d_pkg::coord_type  second_y;
   pit3d_pkg::coord_type  second_z;
   pit3d_pkg::coord_type  third_x;
   pit3d_pkg::coord_type  third_y;
   pit3d_pkg::coord_type  third_z;

   modport source (
      output valid, point_x, point_y, point_z, first_x, first_y, first_z,
             second_x, second_y, second_z, third_x, third_y, third_z,
      input  ready
   );

   modport sink (
      input  valid, point_x, point_y, point_z, first_x, first_y, first_z,
             second_x, second_y, second_z, third_x, third_y, third_z,
      output ready
   );
endinterface

interface pit3d_rsp_if;
   logic valid;
   logic ready;
   logic inside_res;
   logic degenerate;

   modport source (
      output valid, inside_res, degenerate,
      input  ready
   );

   modport sink (
      input  valid, inside_res, degenerate,
      output ready
   );
endinterface

FILE: hw/rtl/point_in_triangle_3d_unit.sv
// ---------------------------------------------------------------------------
// Point in triangle 3D unit
// Barycentric inside test of a 3D point against a triangle, exact integer
// arithmetic with sign tests in place of the divisions.
//
//   channel   dir   handshake           payload
//   req_chan  in    valid / ready       point, first, second, third (x, y, z)
//   rsp_chan  out   valid / ready       inside_res, degenerate
//
// One item per cycle sustained while rsp_chan.ready stays high.
// Stages: offsets, component products, dots, partial products of the six
// wide products, their sums, numerators, sign tests into the rsp register.
// Reset (synchronous) clears the stage valid bits only.
// Under rsp stall each stage holds when it and every stage after it are full;
// empty stages still fill, so req_chan.ready drops only once all seven stages hold items.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "point_in_triangle_3d_unit_macros.svh"

module point_in_triangle_3d_unit (
   input  logic       clock,
   input  logic       reset,
   pit3d_req_if.sink  req_chan,
   pit3d_rsp_if.source rsp_chan
);

   pit3d_pkg::pipe_ctrl_type ctrl;
   pit3d_pkg::vec3_type      point, first, second, third;
   pit3d_pkg::dot_type       d00, d01, d11, d20, d21;
   pit3d_pkg::prod2_type     p00_11, p01_01, p11_20, p01_21, p00_21, p01_20;

   assign point  = '{x: req_chan.point_x,  y: req_chan.point_y,  z: req_chan.point_z};
   assign first  = '{x: req_chan.first_x,  y: req_chan.first_y,  z: req_chan.first_z};
   assign second = '{x: req_chan.second_x, y: req_chan.second_y, z: req_chan.second_z};
   assign third  = '{x: req_chan.third_x,  y: req_chan.third_y,  z: req_chan.third_z};

   pit3d_pipe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .in_ready  (req_chan.ready),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .ctrl      (ctrl)
   );

   pit3d_dot_front u_front (
      .clock  (clock),
      .ctrl   (ctrl),
      .point  (point),
      .first  (first),
      .second (second),
      .third  (third),
      .d00    (d00),
      .d01    (d01),
      .d11    (d11),
      .d20    (d20),
      .d21    (d21)
   );

   pit3d_wide_mul u_mul_00_11 (.clock(clock), .ctrl(ctrl), .a(d00), .b(d11), .p(p00_11));
   pit3d_wide_mul u_mul_01_01 (.clock(clock), .ctrl(ctrl), .a(d01), .b(d01), .p(p01_01));
   pit3d_wide_mul u_mul_11_20 (.clock(clock), .ctrl(ctrl), .a(d11), .b(d20), .p(p11_20));
   pit3d_wide_mul u_mul_01_21 (.clock(clock), .ctrl(ctrl), .a(d01), .b(d21), .p(p01_21));
   pit3d_wide_mul u_mul_00_21 (.clock(clock), .ctrl(ctrl), .a(d00), .b(d21), .p(p00_21));
   pit3d_wide_mul u_mul_01_20 (.clock(clock), .ctrl(ctrl), .a(d01), .b(d20), .p(p01_20));

   pit3d_sign_back u_back (
      .clock      (clock),
      .ctrl       (ctrl),
      .p00_11     (p00_11),
      .p01_01     (p01_01),
      .p11_20     (p11_20),
      .p01_21     (p01_21),
      .p00_21     (p00_21),
      .p01_20     (p01_20),
      .inside_res (rsp_chan.inside_res),
      .degenerate (rsp_chan.degenerate)
   );

   `PIT3D_ASSERT_IMP(a_degen_outside, clock, reset, rsp_chan.valid, !(rsp_chan.inside_res && rsp_chan.degenerate), "degenerate triangle reported inside")

endmodule

FILE: hw/rtl/pit3d_pipe_ctrl.sv
// ---------------------------------------------------------------------------
// Point in triangle 3D pipeline control
// Per-stage valid bits and load enables; a stage loads when it is empty or
// when the stage after it moves on, so bubbles close up under stall.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "point_in_triangle_3d_unit_macros.svh"

module pit3d_pipe_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   output logic                     out_valid,
   input  logic                     out_ready,
   output pit3d_pkg::pipe_ctrl_type ctrl
);

   logic [pit3d_pkg::NUM_STAGES-1:0] valid_ff;
   logic [pit3d_pkg::NUM_STAGES-1:0] valid_in;
   logic [pit3d_pkg::NUM_STAGES-1:0] load;
   logic [pit3d_pkg::NUM_STAGES-1:0] valid_up;

   always_comb begin
      load[pit3d_pkg::NUM_STAGES-1] = !valid_ff[pit3d_pkg::NUM_STAGES-1] || out_ready;
      for (int k = pit3d_pkg::NUM_STAGES - 2; k >= 0; k--) begin
         load[k] = !valid_ff[k] || load[k+1];
      end
   end

   assign valid_up = {valid_ff[pit3d_pkg::NUM_STAGES-2:0], in_valid};
   assign valid_in = (load & valid_up) | (~load & valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign in_ready  = load[0];
   assign out_valid = valid_ff[pit3d_pkg::NUM_STAGES-1];
   assign ctrl.load = load;

   `PIT3D_ASSERT_NXT(a_accept_lands, clock, reset, in_valid && in_ready, valid_ff[0], "accepted item missing from first stage")
   `PIT3D_ASSERT_IMP(a_full_blocks, clock, reset, (&valid_ff) && !out_ready, !in_ready, "item taken into a full stalled pipeline")

endmodule

FILE: hw/rtl/pit3d_dot_front.sv
// ---------------------------------------------------------------------------
// Point in triangle 3D front end
// Edge vectors and point offset, component products, then the five dot
// products, over three register stages.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pit3d_dot_front (
   input  logic                     clock,
   input  pit3d_pkg::pipe_ctrl_type ctrl,
   input  pit3d_pkg::vec3_type      point,
   input  pit3d_pkg::vec3_type      first,
   input  pit3d_pkg::vec3_type      second,
   input  pit3d_pkg::vec3_type      third,
   output pit3d_pkg::dot_type       d00,
   output pit3d_pkg::dot_type       d01,
   output pit3d_pkg::dot_type       d11,
   output pit3d_pkg::dot_type       d20,
   output pit3d_pkg::dot_type       d21
);

   function automatic pit3d_pkg::diff_type sub_ext(input pit3d_pkg::coord_type a,
                                                   input pit3d_pkg::coord_type b);
      return {a[pit3d_pkg::COORD_WIDTH-1], a} - {b[pit3d_pkg::COORD_WIDTH-1], b};
   endfunction

   pit3d_pkg::coord_type pa [3];
   pit3d_pkg::coord_type fa [3];
   pit3d_pkg::coord_type sa [3];
   pit3d_pkg::coord_type ta [3];

   pit3d_pkg::diff_type  e0_in [3];
   pit3d_pkg::diff_type  e1_in [3];
   pit3d_pkg::diff_type  e2_in [3];
   pit3d_pkg::diff_type  e0_ff [3];
   pit3d_pkg::diff_type  e1_ff [3];
   pit3d_pkg::diff_type  e2_ff [3];

   pit3d_pkg::prod1_type prod_in [5][3];
   pit3d_pkg::prod1_type prod_ff [5][3];

   pit3d_pkg::dot_type   dot_in [5];
   pit3d_pkg::dot_type   dot_ff [5];

   always_comb begin
      pa[0] = point.x;  pa[1] = point.y;  pa[2] = point.z;
      fa[0] = first.x;  fa[1] = first.y;  fa[2] = first.z;
      sa[0] = second.x; sa[1] = second.y; sa[2] = second.z;
      ta[0] = third.x;  ta[1] = third.y;  ta[2] = third.z;
      for (int k = 0; k < 3; k++) begin
         e0_in[k] = sub_ext(sa[k], fa[k]);
         e1_in[k] = sub_ext(ta[k], fa[k]);
         e2_in[k] = sub_ext(pa[k], fa[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[pit3d_pkg::STG_DIFF]) begin
         e0_ff <= e0_in;
         e1_ff <= e1_in;
         e2_ff <= e2_in;
      end
   end

   // dot order: d00, d01, d11, d20, d21
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         prod_in[0][k] = e0_ff[k] * e0_ff[k];
         prod_in[1][k] = e0_ff[k] * e1_ff[k];
         prod_in[2][k] = e1_ff[k] * e1_ff[k];
         prod_in[3][k] = e2_ff[k] * e0_ff[k];
         prod_in[4][k] = e2_ff[k] * e1_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[pit3d_pkg::STG_PROD]) begin
         prod_ff <= prod_in;
      end
   end

   always_comb begin
      for (int i = 0; i < 5; i++) begin
         dot_in[i] = pit3d_pkg::dot_type'(prod_ff[i][0])
                   + pit3d_pkg::dot_type'(prod_ff[i][1])
                   + pit3d_pkg::dot_type'(prod_ff[i][2]);
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[pit3d_pkg::STG_DOT]) begin
         dot_ff <= dot_in;
      end
   end

   assign d00 = dot_ff[0];
   assign d01 = dot_ff[1];
   assign d11 = dot_ff[2];
   assign d20 = dot_ff[3];
   assign d21 = dot_ff[4];

endmodule

FILE: hw/rtl/pit3d_wide_mul.sv
// ---------------------------------------------------------------------------
// Point in triangle 3D wide multiplier
// Signed dot-by-dot product split into four half-width partial products,
// registered, then summed in the following stage.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pit3d_wide_mul (
   input  logic                     clock,
   input  pit3d_pkg::pipe_ctrl_type ctrl,
   input  pit3d_pkg::dot_type       a,
   input  pit3d_pkg::dot_type       b,
   output pit3d_pkg::prod2_type     p
);

   localparam int HI_W = pit3d_pkg::HI_W;
   localparam int LO_W = pit3d_pkg::LO_W;

   logic signed [HI_W-1:0]      a_hi;
   logic signed [HI_W-1:0]      b_hi;
   logic        [LO_W-1:0]      a_lo;
   logic        [LO_W-1:0]      b_lo;

   logic signed [2*HI_W-1:0]    hh_in, hh_ff;
   logic signed [HI_W+LO_W:0]   hl_in, hl_ff;
   logic signed [HI_W+LO_W:0]   lh_in, lh_ff;
   logic        [2*LO_W-1:0]    ll_in, ll_ff;

   pit3d_pkg::prod2_type        prod_in, prod_ff;

   always_comb begin
      a_hi  = a[pit3d_pkg::DOT_W-1:LO_W];
      b_hi  = b[pit3d_pkg::DOT_W-1:LO_W];
      a_lo  = a[LO_W-1:0];
      b_lo  = b[LO_W-1:0];
      hh_in = a_hi * b_hi;
      hl_in = a_hi * $signed({1'b0, b_lo});
      lh_in = $signed({1'b0, a_lo}) * b_hi;
      ll_in = a_lo * b_lo;
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[pit3d_pkg::STG_PART]) begin
         hh_ff <= hh_in;
         hl_ff <= hl_in;
         lh_ff <= lh_in;
         ll_ff <= ll_in;
      end
   end

   assign prod_in = (pit3d_pkg::prod2_type'(hh_ff) <<< (2 * LO_W))
                  + (pit3d_pkg::prod2_type'(hl_ff) <<< LO_W)
                  + (pit3d_pkg::prod2_type'(lh_ff) <<< LO_W)
                  + pit3d_pkg::prod2_type'(ll_ff);

   always_ff @(posedge clock) begin
      if (ctrl.load[pit3d_pkg::STG_MUL]) begin
         prod_ff <= prod_in;
      end
   end

   assign p = prod_ff;

endmodule

FILE: hw/rtl/pit3d_sign_back.sv
// ---------------------------------------------------------------------------
// Point in triangle 3D back end
// Determinant and barycentric numerators, then the sign tests that stand in
// for the divisions; the last register is the response register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pit3d_sign_back (
   input  logic                     clock,
   input  pit3d_pkg::pipe_ctrl_type ctrl,
   input  pit3d_pkg::prod2_type     p00_11,
   input  pit3d_pkg::prod2_type     p01_01,
   input  pit3d_pkg::prod2_type     p11_20,
   input  pit3d_pkg::prod2_type     p01_21,
   input  pit3d_pkg::prod2_type     p00_21,
   input  pit3d_pkg::prod2_type     p01_20,
   output logic                     inside_res,
   output logic                     degenerate
);

   pit3d_pkg::res_type den_in, den_ff;
   pit3d_pkg::res_type nv_in, nv_ff;
   pit3d_pkg::res_type nw_in, nw_ff;
   pit3d_pkg::res_type nu;
   logic               degen;
   logic               inside_in, inside_ff;
   logic               degen_ff;

   always_comb begin
      den_in = pit3d_pkg::res_type'(p00_11) - pit3d_pkg::res_type'(p01_01);
      nv_in  = pit3d_pkg::res_type'(p11_20) - pit3d_pkg::res_type'(p01_21);
      nw_in  = pit3d_pkg::res_type'(p00_21) - pit3d_pkg::res_type'(p01_20);
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[pit3d_pkg::STG_NUMER]) begin
         den_ff <= den_in;
         nv_ff  <= nv_in;
         nw_ff  <= nw_in;
      end
   end

   // u weight numerator: den - nv - nw
   always_comb begin
      nu        = den_ff - nv_ff - nw_ff;
      degen     = (den_ff == '0);
      inside_in = !degen && !nv_ff[pit3d_pkg::RES_W-1] && !nw_ff[pit3d_pkg::RES_W-1]
                  && !nu[pit3d_pkg::RES_W-1];
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[pit3d_pkg::STG_OUT]) begin
         inside_ff <= inside_in;
         degen_ff  <= degen;
      end
   end

   assign inside_res = inside_ff;
   assign degenerate = degen_ff;

endmodule

FILE: tb/sv/point_in_triangle_3d_unit_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Point in triangle 3D unit testbench
// Streams point/triangle queries into the unit and checks every response.
// The expected result is computed with exact signed arithmetic: edge vectors,
// dot products, determinant and barycentric numerators, then sign tests.
// Directed queries cover vertices, edges, degenerate triangles and extreme
// coordinates. Random queries use lattice-built triangles with points inside,
// on the boundary and outside, plus full-range noise. Both channels idle at
// random, the response side holds off long enough to fill the pipeline, and
// the final stretch runs without idling.
// ---------------------------------------------------------------------------

typedef struct packed {
   pit3d_pkg::vec3_type pt;
   pit3d_pkg::vec3_type va;
   pit3d_pkg::vec3_type vb;
   pit3d_pkg::vec3_type vc;
} query_type;

typedef struct {
   logic inside_res;
   logic degenerate;
} verdict_type;

class inside_test_scoreboard;
   verdict_type expected_verdicts[$];
   int          mismatches = 0;

   function verdict_type barycentric_verdict(query_type q);
      pit3d_pkg::diff_type e0[3], e1[3], e2[3];
      pit3d_pkg::dot_type  d00, d01, d11, d20, d21;
      pit3d_pkg::res_type  den, nv, nw, nu;
      verdict_type         v;
      e0[0] = q.vb.x - q.va.x;
      e0[1] = q.vb.y - q.va.y;
      e0[2] = q.vb.z - q.va.z;
      e1[0] = q.vc.x - q.va.x;
      e1[1] = q.vc.y - q.va.y;
      e1[2] = q.vc.z - q.va.z;
      e2[0] = q.pt.x - q.va.x;
      e2[1] = q.pt.y - q.va.y;
      e2[2] = q.pt.z - q.va.z;
      d00 = e0[0] * e0[0] + e0[1] * e0[1] + e0[2] * e0[2];
      d01 = e0[0] * e1[0] + e0[1] * e1[1] + e0[2] * e1[2];
      d11 = e1[0] * e1[0] + e1[1] * e1[1] + e1[2] * e1[2];
      d20 = e2[0] * e0[0] + e2[1] * e0[1] + e2[2] * e0[2];
      d21 = e2[0] * e1[0] + e2[1] * e1[1] + e2[2] * e1[2];
      den = d00 * d11 - d01 * d01;
      nv  = d11 * d20 - d01 * d21;
      nw  = d00 * d21 - d01 * d20;
      nu  = den - nv - nw;
      v.degenerate = (den == 0);
      v.inside_res = !v.degenerate && !nv[pit3d_pkg::RES_W-1] &&
                     !nw[pit3d_pkg::RES_W-1] && !nu[pit3d_pkg::RES_W-1];
      return v;
   endfunction

   function void note_query(query_type q);
      expected_verdicts.push_back(barycentric_verdict(q));
   endfunction

   function void check_verdict(logic inside_res, logic degenerate);
      verdict_type exp_v;
      if (expected_verdicts.size() == 0) begin
         $error("response item with no query outstanding");
         mismatches++;
         return;
      end
      exp_v = expected_verdicts.pop_front();
      if (inside_res !== exp_v.inside_res) begin
         $error("inside_res: expected %0b, actual %0b", exp_v.inside_res, inside_res);
         mismatches++;
      end
      if (degenerate !== exp_v.degenerate) begin
         $error("degenerate: expected %0b, actual %0b", exp_v.degenerate, degenerate);
         mismatches++;
      end
   endfunction

   function int pending();
      return expected_verdicts.size();
   endfunction
endclass

module point_in_triangle_3d_unit_tb;

   localparam int RANDOM_ITEMS = 1530;
   localparam int HOLD_CYCLES  = 40;
   localparam int CYCLE_LIMIT  = 200000;

   logic        clock = 1'b0;
   logic        reset;
   bit          idling = 1'b1;
   bit          hold_request = 1'b0;
   int unsigned cycles = 0;

   inside_test_scoreboard sb = new;

   pit3d_req_if req ();
   pit3d_rsp_if rsp ();

   point_in_triangle_3d_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req),
      .rsp_chan (rsp)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("point_in_triangle_3d_unit test failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp.valid === 1'b1 && rsp.ready)
         sb.check_verdict(rsp.inside_res, rsp.degenerate);
   end

   function automatic pit3d_pkg::vec3_type v3(int x, int y, int z);
      pit3d_pkg::vec3_type r;
      r.x = pit3d_pkg::coord_type'(x);
      r.y = pit3d_pkg::coord_type'(y);
      r.z = pit3d_pkg::coord_type'(z);
      return r;
   endfunction

   function automatic int rnd_coord(int lim);
      return int'($urandom_range(0, 2 * lim)) - lim;
   endfunction

   // lattice triangle: B = A + m*s, C = A + m*t, point = A + i*s + j*t
   function automatic query_type random_query();
      int        ext[7] = '{-32768, -32767, -1, 0, 1, 32766, 32767};
      int        a[3], b[3], c[3], p[3], s[3], t[3];
      int        kind, m, i, j, k, lim;
      query_type q;
      kind = $urandom_range(0, 9);
      m    = $urandom_range(1, 8);
      lim  = 4000 / m;
      for (k = 0; k < 3; k++) begin
         a[k] = rnd_coord(8000);
         s[k] = rnd_coord(lim);
         t[k] = rnd_coord(lim);
      end
      case ($urandom_range(0, 4))
         0: begin
            i = $urandom_range(0, m);
            j = m - i;
         end
         1: begin
            i = 0;
            j = $urandom_range(0, m);
         end
         2: begin
            i = $urandom_range(0, m);
            j = 0;
         end
         3: begin
            i = $urandom_range(0, m + 1);
            j = $urandom_range(0, m + 1);
         end
         default: begin
            i = $urandom_range(0, m);
            j = $urandom_range(0, m - i);
         end
      endcase
      for (k = 0; k < 3; k++) begin
         b[k] = a[k] + m * s[k];
         c[k] = a[k] + m * t[k];
         p[k] = a[k] + i * s[k] + j * t[k];
      end
      if ($urandom_range(0, 3) == 0)
         p[2] += rnd_coord(50);
      case (kind)
         0, 1: q = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
         2: begin
            // collinear or coincident vertices
            for (k = 0; k < 3; k++) begin
               b[k] = ($urandom_range(0, 3) == 0) ? a[k] : a[k] + s[k];
               c[k] = (b[k] == a[k]) ? a[k] : a[k] + m * s[k];
            end
            q = {v3(p[0], p[1], p[2]), v3(a[0], a[1], a[2]),
                 v3(b[0], b[1], b[2]), v3(c[0], c[1], c[2])};
         end
         3: q = {v3(rnd_coord(4), rnd_coord(4), rnd_coord(4)),
                 v3(rnd_coord(4), rnd_coord(4), rnd_coord(4)),
                 v3(rnd_coord(4), rnd_coord(4), rnd_coord(4)),
                 v3(rnd_coord(4), rnd_coord(4), rnd_coord(4))};
         4: q = {v3(ext[$urandom_range(0, 6)], ext[$urandom_range(0, 6)],
                    ext[$urandom_range(0, 6)]),
                 v3(ext[$urandom_range(0, 6)], ext[$urandom_range(0, 6)],
                    ext[$urandom_range(0, 6)]),
                 v3(ext[$urandom_range(0, 6)], ext[$urandom_range(0, 6)],
                    ext[$urandom_range(0, 6)]),
                 v3(ext[$urandom_range(0, 6)], ext[$urandom_range(0, 6)],
                    ext[$urandom_range(0, 6)])};
         default: q = {v3(p[0], p[1], p[2]), v3(a[0], a[1], a[2]),
                       v3(b[0], b[1], b[2]), v3(c[0], c[1], c[2])};
      endcase
      return q;
   endfunction

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_query(input query_type q);
      if (idling && $urandom_range(0, 3) == 0) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req.point_x  <= q.pt.x;
      req.point_y  <= q.pt.y;
      req.point_z  <= q.pt.z;
      req.first_x  <= q.va.x;
      req.first_y  <= q.va.y;
      req.first_z  <= q.va.z;
      req.second_x <= q.vb.x;
      req.second_y <= q.vb.y;
      req.second_z <= q.vb.z;
      req.third_x  <= q.vc.x;
      req.third_y  <= q.vc.y;
      req.third_z  <= q.vc.z;
      req.valid    <= 1'b1;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      sb.note_query(q);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      while (sb.pending() != 0) @(negedge clock);
   endtask

   initial begin
      rsp.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp.ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
         end else if (idling && $urandom_range(0, 4) == 0) begin
            rsp.ready <= 1'b0;
            repeat ($urandom_range(1, 3) - 1) @(negedge clock);
         end else begin
            rsp.ready <= 1'b1;
         end
      end
   end

   initial begin
      int n;
      reset        = 1'b1;
      req.valid    = 1'b0;
      req.point_x  = '0;
      req.point_y  = '0;
      req.point_z  = '0;
      req.first_x  = '0;
      req.first_y  = '0;
      req.first_z  = '0;
      req.second_x = '0;
      req.second_y = '0;
      req.second_z = '0;
      req.third_x  = '0;
      req.third_y  = '0;
      req.third_z  = '0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // inside, vertices, edges, outside, off-plane projection
      send_query({v3(2, 2, 0), v3(0, 0, 0), v3(10, 0, 0), v3(0, 10, 0)});
      send_query({v3(0, 0, 0), v3(0, 0, 0), v3(10, 0, 0), v3(0, 10, 0)});
      send_query({v3(10, 0, 0), v3(0, 0, 0), v3(10, 0, 0), v3(0, 10, 0)});
      send_query({v3(5, 5, 0), v3(0, 0, 0), v3(10, 0, 0), v3(0, 10, 0)});
      send_query({v3(5, 0, 0), v3(0, 0, 0), v3(10, 0, 0), v3(0, 10, 0)});
      send_query({v3(11, 11, 0), v3(0, 0, 0), v3(10, 0, 0), v3(0, 10, 0)});
      send_query({v3(-1, 2, 0), v3(0, 0, 0), v3(10, 0, 0), v3(0, 10, 0)});
      send_query({v3(2, 2, 100), v3(0, 0, 0), v3(10, 0, 0), v3(0, 10, 0)});
      send_query({v3(1, 1, 0), v3(0, 0, 0), v3(1, 0, 0), v3(0, 1, 0)});
      send_query({v3(0, 1, 0), v3(0, 0, 0), v3(1, 0, 0), v3(0, 1, 0)});
      // degenerate triangles
      send_query({v3(7, 7, 7), v3(7, 7, 7), v3(7, 7, 7), v3(7, 7, 7)});
      send_query({v3(2, 2, 2), v3(0, 0, 0), v3(1, 1, 1), v3(5, 5, 5)});
      send_query({v3(3, 1, 0), v3(3, 4, 5), v3(3, 4, 5), v3(-9, 2, 8)});
      send_query({v3(-32768, -32768, -32768), v3(-32768, -32768, -32768),
                  v3(-32768, -32768, -32768), v3(-32768, -32768, -32768)});
      send_query({v3(32767, 32767, 32767), v3(32767, 32767, 32767),
                  v3(32767, 32767, 32767), v3(32767, 32767, 32767)});
      // full-range coordinates
      send_query({v3(0, 0, 0), v3(-32768, -32768, -32768),
                  v3(32767, -32768, -32768), v3(-32768, 32767, 32767)});
      send_query({v3(32767, 32767, 32767), v3(-32768, -32768, -32768),
                  v3(32767, -32768, -32768), v3(-32768, 32767, 32767)});
      send_query({v3(-32768, 32767, -32768), v3(32767, 32767, 32767),
                  v3(-32768, 32767, -32768), v3(32767, -32768, 32767)});
      send_query({v3(0, 0, 0), v3(32767, -32768, 0),
                  v3(-32768, 32767, 0), v3(32767, 32767, -32768)});

      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == 300) begin
            idling       = 1'b0;
            hold_request = 1'b1;
         end
         if (n == 360)
            idling = 1'b1;
         if (n == 600) begin
            req.valid <= 1'b0;
            wait_drained();
         end
         if (n == 1250)
            idling = 1'b0;
         send_query(random_query());
      end

      req.valid <= 1'b0;
      wait_drained();
      repeat (16) @(negedge clock);
      if (sb.mismatches == 0)
         $display("point_in_triangle_3d_unit test passed");
      else
         $display("point_in_triangle_3d_unit test failed");
      $finish;
   end

endmodule
